>>> src/arbl_pkg.sv
// arbl_pkg: shared widths, opcodes, state and result types for the address range lookup
// no dependencies; compile first
package arbl_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CNT_W  = 6;

  // default table depth
  localparam int unsigned DEF_MAX_SLOTS = 32;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } arbl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } arbl_state_e;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] match_slot;
  } arbl_res_t;

endpackage

>>> src/arbl_if.sv
// arbl_in_if / arbl_out_if: valid/ready channels for input items and lookup results
// depends on arbl_pkg
interface arbl_in_if;
  import arbl_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] range_low;
  logic [ADDR_W-1:0] range_high;
  logic [ADDR_W-1:0] address;

  modport source (output valid, opcode, slot, range_low, range_high, address, input ready);
  modport sink   (input valid, opcode, slot, range_low, range_high, address, output ready);
endinterface

interface arbl_out_if;
  import arbl_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] match_slot;

  modport source (output valid, hit, match_slot, input ready);
  modport sink   (input valid, hit, match_slot, output ready);
endinterface

>>> src/address_range_binary_lookup.sv
// address_range_binary_lookup: top level, range table loads and binary-search lookups
// depends on arbl_pkg, arbl_if, arbl_ram, arbl_search
//
//   channel   dir  transfer when         payload
//   in_i      in   valid && ready        opcode, slot, range_low, range_high, address
//   out_o     out  valid && ready        hit, match_slot
//   cfg       in   cfg_we_i              cfg_wdata_i -> entry_count
//
// a load leaves the sequencer idle; the next item may follow in the cycle after it
// a lookup over n slots makes at most P probes before its result is registered, P = ceil(log2 n) + 1
//   (6 probes for 32 slots); with an empty table it makes no probe and goes straight to done
// P is set by the read-compare loop on the single bounds RAM: one probe per cycle
// rst_ni clears the sequencer, the output register's valid bit and entry_count, not the RAM
// a held result sits in the output register; the sequencer stalls only when both are full
module address_range_binary_lookup #(
  parameter int unsigned MaxSlots = arbl_pkg::DEF_MAX_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  arbl_in_if.sink                    in_i,
  arbl_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [arbl_pkg::CNT_W-1:0] cfg_wdata_i
);
  import arbl_pkg::*;

  localparam int unsigned CntW = $clog2(MaxSlots + 1);

  // entry_count register
  logic [CNT_W-1:0] cfg_q;
  // count after clamping to the table depth
  logic [CntW-1:0]  count;

  arbl_res_t res;
  logic      res_valid;
  logic      res_ready;

  // output register
  logic      out_valid_q, out_valid_d;
  arbl_res_t out_res_q, out_res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // an oversized count searches the whole table
  assign count = (32'(cfg_q) > MaxSlots) ? CntW'(MaxSlots) : CntW'(cfg_q);

  arbl_search #(
    .MaxSlots (MaxSlots)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .count_i     (count),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_res_q.hit;
  assign out_o.match_slot = out_res_q.match_slot;

  // a lookup transfer closes the input straight after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_LOOKUP) |=> !in_i.ready)
    else $error("input open right after a lookup transfer");

  // loads never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_LOAD) |=> in_i.ready)
    else $error("input closed after a load transfer");

  // a miss always reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.hit |-> (out_o.match_slot == '0))
    else $error("miss with nonzero slot");

  // a new result is never taken while the previous one is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && res_valid |=> res_valid)
    else $error("result dropped while output register full");

endmodule

>>> src/arbl_ram.sv
// arbl_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module arbl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/arbl_search.sv
// arbl_search: load/lookup sequencer around the bounds RAM, one probe per cycle
// depends on arbl_pkg, arbl_if, arbl_ram
module arbl_search #(
  parameter int unsigned MaxSlots = arbl_pkg::DEF_MAX_SLOTS,
  localparam int unsigned CntW = $clog2(MaxSlots + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  arbl_in_if.sink             in_i,
  input  logic [CntW-1:0]     count_i,
  output arbl_pkg::arbl_res_t res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i
);
  import arbl_pkg::*;

  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned EntW = 2 * ADDR_W;

  arbl_state_e       state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IdxW-1:0]   base_q, base_d;
  logic [IdxW-1:0]   probe_q, probe_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  arbl_res_t         res_q, res_d;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntW-1:0]   ram_wdata, ram_rdata;

  logic              load_acc, look_acc, slot_ok;
  logic [ADDR_W-1:0] ent_low, ent_high;
  logic              below, above, found, last;
  logic [CntW-1:0]   mid, nxt_cnt;
  logic [IdxW-1:0]   nxt_base;

  assign in_i.ready = (state_q == ST_IDLE);
  assign load_acc   = in_i.valid && in_i.ready && (in_i.opcode == OP_LOAD);
  assign look_acc   = in_i.valid && in_i.ready && (in_i.opcode == OP_LOOKUP);
  assign slot_ok    = 32'(in_i.slot) < MaxSlots;

  // writes happen only while idle, so no probe can overlap a write
  assign ram_we    = load_acc && slot_ok;
  assign ram_waddr = IdxW'(in_i.slot);
  assign ram_wdata = {in_i.range_low, in_i.range_high};

  arbl_ram #(
    .Width (EntW),
    .Depth (MaxSlots)
  ) u_bounds_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (probe_d),
    .rdata_o (ram_rdata)
  );

  // compare the probed entry and pick the surviving half
  assign ent_low  = ram_rdata[EntW-1:ADDR_W];
  assign ent_high = ram_rdata[ADDR_W-1:0];
  assign below    = addr_q < ent_low;
  assign above    = addr_q > ent_high;
  assign found    = !below && !above;
  assign last     = (cnt_q <= CntW'(1));
  assign mid      = cnt_q >> 1;
  assign nxt_base = below ? base_q : probe_q;
  assign nxt_cnt  = below ? mid : (cnt_q - mid);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (look_acc) begin
          state_d = (count_i == '0) ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (found || last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    addr_d  = addr_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    probe_d = probe_q;
    res_d   = res_q;
    ram_re  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (look_acc) begin
          addr_d  = in_i.address;
          base_d  = '0;
          cnt_d   = count_i;
          probe_d = IdxW'(count_i >> 1);
          ram_re  = (count_i != '0);
          res_d   = '0;
        end
      end
      ST_SEARCH: begin
        if (found) begin
          res_d.hit        = 1'b1;
          res_d.match_slot = SLOT_W'(probe_q);
        end else if (last) begin
          res_d = '0;
        end else begin
          base_d  = nxt_base;
          cnt_d   = nxt_cnt;
          // with one candidate left the probe is the base itself
          probe_d = IdxW'(nxt_base + (nxt_cnt >> 1));
          ram_re  = 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    base_q  <= base_d;
    cnt_q   <= cnt_d;
    probe_q <= probe_d;
    res_q   <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = (state_q == ST_DONE);

endmodule

>>> dv/address_range_binary_lookup_test.sv
// address_range_binary_lookup_test: self-checking bench for the address range lookup block
// depends on arbl_pkg, arbl_if and the address_range_binary_lookup rtl
// sorted range tables are loaded, entry_count is swept and lookups are checked in order
module address_range_binary_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arbl_pkg::*;

  localparam int unsigned MAX_SLOTS     = DEF_MAX_SLOTS;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned TOTAL_ITEMS   = 1820;
  localparam int unsigned SETTLE_CYCLES = 16;    // margin after the slowest lookup, loads leave no result
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned LONG_HOLD     = 300;   // receiver back-pressure stretch
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles without any transfer
  localparam int unsigned MAX_REPORTS   = 10;

  // one input item as driven on the in channel
  typedef struct {
    arbl_op_e          op;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] range_low;
    logic [ADDR_W-1:0] range_high;
    logic [ADDR_W-1:0] address;
  } range_item_t;

  // predicted outcome of one lookup, the address kept for messages
  typedef struct {
    logic [ADDR_W-1:0] address;
    arbl_res_t         res;
  } lookup_outcome_t;

  // mirror of the range table plus the queue of lookup outcomes still to come
  class lookup_scoreboard;
    logic [ADDR_W-1:0] low_bound [MAX_SLOTS];
    logic [ADDR_W-1:0] high_bound [MAX_SLOTS];
    logic [CNT_W-1:0]  entry_count;
    lookup_outcome_t   predicted_matches [$];
    int unsigned       errors;

    function new();
      entry_count = '0;
      errors      = 0;
      foreach (low_bound[i]) begin
        low_bound[i]  = '0;
        high_bound[i] = '0;
      end
    endfunction

    function void set_entry_count(logic [CNT_W-1:0] value);
      entry_count = value;
    endfunction

    function int unsigned pending();
      return predicted_matches.size();
    endfunction

    // binary search over the active slots, probing at half the remaining count
    function arbl_res_t search_table(logic [ADDR_W-1:0] addr);
      int unsigned count;
      int unsigned base;
      int unsigned half;
      int unsigned idx;
      arbl_res_t   res;
      res   = '0;
      count = (entry_count > MAX_SLOTS) ? MAX_SLOTS : entry_count;
      base  = 0;
      while (count > 1) begin
        half = count / 2;
        idx  = base + half;
        if (addr < low_bound[idx]) begin
          count = half;
        end else if (addr > high_bound[idx]) begin
          base  = idx;
          count = count - half;
        end else begin
          res.hit        = 1'b1;
          res.match_slot = idx[SLOT_W-1:0];
          return res;
        end
      end
      if (count == 1 && low_bound[base] <= addr && high_bound[base] >= addr) begin
        res.hit        = 1'b1;
        res.match_slot = base[SLOT_W-1:0];
      end
      return res;
    endfunction

    function void note_item(range_item_t item);
      lookup_outcome_t outcome;
      if (item.op == OP_LOAD) begin
        low_bound[item.slot]  = item.range_low;
        high_bound[item.slot] = item.range_high;
      end else begin
        outcome.address = item.address;
        outcome.res     = search_table(item.address);
        predicted_matches.push_back(outcome);
      end
    endfunction

    function void check_result(arbl_res_t got);
      lookup_outcome_t want;
      if (predicted_matches.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no lookup pending: hit=%0b slot=%0d",
                   $realtime, got.hit, got.match_slot);
        return;
      end
      want = predicted_matches.pop_front();
      if (got.hit !== want.res.hit || got.match_slot !== want.res.match_slot) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: lookup of %h: expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                   $realtime, want.address, want.res.hit, want.res.match_slot,
                   got.hit, got.match_slot);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  arbl_in_if  in_if ();
  arbl_out_if out_if ();

  lookup_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  bit          offering;        // in valid is currently high
  bit          hold_request;    // ask the receiver for a long hold-off

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  address_range_binary_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic range_item_t make_load(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] lo,
                                            logic [ADDR_W-1:0] hi);
    range_item_t item;
    item.op         = OP_LOAD;
    item.slot       = slot;
    item.range_low  = lo;
    item.range_high = hi;
    item.address    = ADDR_W'($urandom());   // ignored by a load
    return item;
  endfunction

  function automatic range_item_t make_lookup(logic [ADDR_W-1:0] addr);
    range_item_t item;
    item.op         = OP_LOOKUP;
    item.slot       = SLOT_W'($urandom());   // slot and bounds are don't-care for lookups
    item.range_low  = ADDR_W'($urandom());
    item.range_high = ADDR_W'($urandom());
    item.address    = addr;
    return item;
  endfunction

  // mostly addresses at or around a loaded range, some anywhere
  function automatic logic [ADDR_W-1:0] pick_address(int unsigned rows);
    int unsigned       s;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    if (rows == 0 || $urandom_range(9) == 0) return ADDR_W'($urandom());
    s  = $urandom_range(rows - 1);
    lo = sb.low_bound[s];
    hi = sb.high_bound[s];
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      default: begin
        if (lo <= hi) return lo + ADDR_W'($urandom_range(hi - lo));
        return lo;
      end
    endcase
  endfunction

  // offer one item and hold it until the block takes it
  task automatic send_item(range_item_t item);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      if (offering) in_if.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= item.op;
    in_if.slot       <= item.slot;
    in_if.range_low  <= item.range_low;
    in_if.range_high <= item.range_high;
    in_if.address    <= item.address;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(item);
    items_sent++;
  endtask

  // stop offering and let every pending lookup come back
  task automatic wait_for_results();
    if (offering) in_if.valid <= 1'b0;
    offering = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // entry_count only changes while the block is idle
  task automatic write_entry_count(logic [CNT_W-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_entry_count(value);
  endtask

  // sorted, non-overlapping ranges in slots 0..rows-1, now and then an inverted one
  task automatic build_table(int unsigned rows);
    int unsigned step;
    int unsigned lo;
    int unsigned hi;
    step = 65536 / rows;
    for (int unsigned i = 0; i < rows; i++) begin
      lo = i * step + $urandom_range(step / 4);
      hi = lo + $urandom_range(step / 2);
      if (i == 0 && $urandom_range(1) == 1) lo = 0;
      if (i == rows - 1 && $urandom_range(1) == 1) hi = 65535;
      if ($urandom_range(11) == 0 && lo > 0) hi = lo - 1;
      if (hi > 65535) hi = 65535;
      send_item(make_load(SLOT_W'(i), ADDR_W'(lo), ADDR_W'(hi)));
    end
  endtask

  // receiver: checks every result transfer, idles at random, holds off on request
  initial begin
    int unsigned hold_left;
    arbl_res_t   got;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.hit        = out_if.hit;
        got.match_slot = out_if.match_slot;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: any cycle with a transfer on either channel restarts the count
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    wait (rst_ni === 1'b1);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned first_counts [5];
    int unsigned edge_counts [7];
    int unsigned phase;
    int unsigned n;
    int unsigned rows;
    int unsigned len;
    bit          hold_done;
    bit          pause_done;

    first_counts = '{63, 32, 1, 2, 33};
    edge_counts  = '{0, 1, 2, 31, 32, 33, 63};
    sb            = new();
    send_idle_pct = 19;
    recv_idle_pct = 47;
    items_sent    = 0;
    offering      = 1'b0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;

    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_LOAD;
    in_if.slot       <= '0;
    in_if.range_low  <= '0;
    in_if.range_high <= '0;
    in_if.address    <= '0;
    out_if.ready     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table after reset, then a small table with an inverted slot
    send_item(make_lookup(16'h0000));
    send_item(make_lookup(16'hffff));
    send_item(make_load(5'd0, 16'h0000, 16'h00ff));
    send_item(make_load(5'd1, 16'h1000, 16'h0fff));   // low above high, never covers
    send_item(make_load(5'd2, 16'h2000, 16'h2fff));
    send_item(make_load(5'd3, 16'hf000, 16'hffff));
    send_item(make_load(5'd31, 16'hffff, 16'h0000));
    write_entry_count(6'd1);
    send_item(make_lookup(16'h0000));
    send_item(make_lookup(16'h00ff));
    send_item(make_lookup(16'h0100));
    write_entry_count(6'd4);
    send_item(make_lookup(16'h1000));                  // steered through the inverted slot
    send_item(make_lookup(16'h0fff));
    send_item(make_lookup(16'h2abc));
    send_item(make_lookup(16'hf000));
    send_item(make_lookup(16'hffff));
    send_item(make_lookup(16'h8000));
    send_item(make_lookup(16'h0050));

    // random phases: rebuild a sorted table, set the count, then mostly lookups
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent < 620) begin
        send_idle_pct = 19;
        recv_idle_pct = 47;
      end else if (items_sent < 1220) begin
        send_idle_pct = 47;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase < 5) n = first_counts[phase];
      else if ($urandom_range(5) == 0) n = edge_counts[$urandom_range(6)];
      else n = $urandom_range(1, MAX_SLOTS);
      rows = (n > MAX_SLOTS) ? MAX_SLOTS : n;   // count above table size is clamped
      if (rows != 0) build_table(rows);
      write_entry_count(CNT_W'(n));
      len = $urandom_range(30, 90);
      repeat (len) begin
        // long receiver hold-off while items keep coming, so the input stalls
        if (!hold_done && items_sent >= 350) begin
          hold_done    = 1'b1;
          hold_request = 1'b1;
        end
        // sender waits for every pending result once
        if (!pause_done && items_sent >= 900) begin
          pause_done = 1'b1;
          wait_for_results();
        end
        if ($urandom_range(15) == 0)
          send_item(make_load(SLOT_W'($urandom()), ADDR_W'($urandom()), ADDR_W'($urandom())));
        else
          send_item(make_lookup(pick_address(rows)));
      end
      phase++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d lookups without result", sb.errors, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/arbl_pkg.sv
src/arbl_if.sv
src/arbl_ram.sv
src/arbl_search.sv
src/address_range_binary_lookup.sv
dv/address_range_binary_lookup_test.sv
